// ===== hdl/fmm_pkg.sv =====
// Shared constants, codes and helpers for the fixed-point matrix multiplier.
`default_nettype none

package fmm_pkg;

   // Matrix geometry
   localparam int MAX_DIM   = 8;
   localparam int FRAC_BITS = 12;
   localparam int DEPTH     = MAX_DIM * MAX_DIM;
   localparam int IDX_W     = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(MAX_DIM);
   localparam int DIM_W     = $clog2(MAX_DIM + 1);
   localparam int PROD_W    = CNT_W + DIM_W;

   // Field widths fixed by the interface
   localparam int CMD_W  = 2;
   localparam int EIDX_W = 6;
   localparam int VAL_W  = 16;
   localparam int RIDX_W = 6;
   localparam int CFG_W  = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 4;

   // Accumulator: full product width plus growth over the inner dimension
   localparam int MUL_W = 2 * VAL_W;
   localparam int ACC_W = MUL_W + $clog2(MAX_DIM) + 1;

   // Commands
   localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
   localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
   localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROWS_A    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INNER_DIM = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COLS_B    = 2'd2;

   localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(MAX_DIM);

   // Per-read tag carried down the multiply pipeline
   typedef struct packed {
      logic              first;
      logic              last;
      logic              final_elem;
      logic [RIDX_W-1:0] ridx;
   } tag_type;

   // Clamp a dimension register into 1..MAX_DIM
   function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
      logic [DIM_W-1:0] d;
      if (v == '0) begin
         d = DIM_W'(1);
      end else if (32'(v) > MAX_DIM) begin
         d = DIM_W'(MAX_DIM);
      end else begin
         d = DIM_W'(v);
      end
      return d;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/fmm_if.sv =====
// Channel interfaces: request, response and register write.
`default_nettype none

interface fmm_req_if import fmm_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        cmd;
   logic [EIDX_W-1:0]       elem_index;
   logic signed [VAL_W-1:0] elem_value;

   modport source (output valid, cmd, elem_index, elem_value, input ready);
   modport sink   (input valid, cmd, elem_index, elem_value, output ready);
endinterface

interface fmm_rsp_if import fmm_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] result_value;
   logic [RIDX_W-1:0]       result_index;
   logic                    result_last;
   logic                    saturated;

   modport source (output valid, result_value, result_index, result_last, saturated,
                   input ready);
   modport sink   (input valid, result_value, result_index, result_last, saturated,
                   output ready);
endinterface

interface fmm_csr_if import fmm_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

// ===== hdl/fmm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fmm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/fixed_point_matrix_multiply_top.sv =====
// Fixed-point matrix multiplier C = A x B over two element memories.
//
//   channel  dir  transaction
//   req_     in   cmd, elem_index, elem_value (write A, write B, compute)
//   rsp_     out  result_value, result_index, result_last, saturated
//   csr_     in   reg_index, wr_data (rows_a, inner_dim, cols_b)
//
// A write is accepted while idle and does not hold the request side. A compute
// holds it from the accepting cycle through one multiply-accumulate per cycle
// while the response is not stalled (limited by the single read port of each
// memory), until the read/multiply/accumulate pipeline has drained.
// Synchronous active-high reset clears control state only; memory contents
// are undefined until written. A stalled response holds the whole pipeline.
`default_nettype none

module fixed_point_matrix_multiply_top import fmm_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   fmm_req_if.sink   req_chan,
   fmm_rsp_if.source rsp_chan,
   fmm_csr_if.sink   csr_chan
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0] state_ff, state_in;

   logic [CFG_W-1:0] rows_a_ff, inner_dim_ff, cols_b_ff;
   logic [DIM_W-1:0] nr, nk, nc;

   logic [CNT_W-1:0] r_ff, r_in, c_ff, c_in, k_ff, k_in;
   logic             r_last, c_last, k_last;

   logic              req_accept, adv, issue;
   logic              wr_a, wr_b, in_range;
   logic [IDX_W-1:0]  wr_addr;
   logic [PROD_W-1:0] ia_full, ib_full, ridx_full;
   logic [IDX_W-1:0]  ia, ib;
   logic [VAL_W-1:0]  a_data, b_data;

   logic    p1_valid_ff, p2_valid_ff;
   tag_type issue_tag, p1_tag_ff, p2_tag_ff;
   logic signed [MUL_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff, sum, shifted;

   localparam logic signed [ACC_W-1:0] Q_MAX = ACC_W'(32767);
   localparam logic signed [ACC_W-1:0] Q_MIN = ACC_W'(-32768);

   logic                    rsp_valid_ff;
   logic signed [VAL_W-1:0] rsp_value_ff;
   logic [RIDX_W-1:0]       rsp_index_ff;
   logic                    rsp_last_ff, rsp_sat_ff;

   // Configuration registers
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= DIM_RESET;
         inner_dim_ff <= DIM_RESET;
         cols_b_ff    <= DIM_RESET;
      end else if (csr_chan.valid) begin
         if (csr_chan.reg_index == REG_ROWS_A)    rows_a_ff    <= csr_chan.wr_data;
         if (csr_chan.reg_index == REG_INNER_DIM) inner_dim_ff <= csr_chan.wr_data;
         if (csr_chan.reg_index == REG_COLS_B)    cols_b_ff    <= csr_chan.wr_data;
      end
   end

   assign nr = eff_dim(rows_a_ff);
   assign nk = eff_dim(inner_dim_ff);
   assign nc = eff_dim(cols_b_ff);

   // Request side and element writes
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign in_range       = (32'(req_chan.elem_index) < DEPTH);
   assign wr_a    = req_accept && (req_chan.cmd == CMD_WRITE_A) && in_range;
   assign wr_b    = req_accept && (req_chan.cmd == CMD_WRITE_B) && in_range;
   assign wr_addr = IDX_W'(req_chan.elem_index);

   // Pipeline advances whenever the output register can take a result
   assign adv   = !rsp_valid_ff || rsp_chan.ready;
   assign issue = (state_ff == ST_RUN) && adv;

   // Loop counters, k innermost
   assign k_last = (DIM_W'(k_ff) + DIM_W'(1)) == nk;
   assign c_last = (DIM_W'(c_ff) + DIM_W'(1)) == nc;
   assign r_last = (DIM_W'(r_ff) + DIM_W'(1)) == nr;

   always_comb begin
      state_in = state_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      k_in     = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_chan.cmd == CMD_COMPUTE)) begin
               state_in = ST_RUN;
               r_in     = '0;
               c_in     = '0;
               k_in     = '0;
            end
         end
         ST_RUN: begin
            if (adv) begin
               if (!k_last) begin
                  k_in = k_ff + CNT_W'(1);
               end else begin
                  k_in = '0;
                  if (!c_last) begin
                     c_in = c_ff + CNT_W'(1);
                  end else begin
                     c_in = '0;
                     if (!r_last) begin
                        r_in = r_ff + CNT_W'(1);
                     end else begin
                        state_in = ST_DRAIN;
                     end
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (!p1_valid_ff && !p2_valid_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         r_ff     <= '0;
         c_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         r_ff     <= r_in;
         c_ff     <= c_in;
         k_ff     <= k_in;
      end
   end

   // Read addresses: A[r][k] and B[k][c], row-major with live dimensions
   assign ia_full   = PROD_W'(r_ff) * PROD_W'(nk) + PROD_W'(k_ff);
   assign ib_full   = PROD_W'(k_ff) * PROD_W'(nc) + PROD_W'(c_ff);
   assign ridx_full = PROD_W'(r_ff) * PROD_W'(nc) + PROD_W'(c_ff);
   assign ia        = ia_full[IDX_W-1:0];
   assign ib        = ib_full[IDX_W-1:0];

   assign issue_tag.first      = (k_ff == '0);
   assign issue_tag.last       = k_last;
   assign issue_tag.final_elem = r_last && c_last;
   assign issue_tag.ridx       = RIDX_W'(ridx_full);

   fmm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data (req_chan.elem_value),
      .rd_en   (issue),
      .rd_addr (ia),
      .rd_data (a_data)
   );

   fmm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data (req_chan.elem_value),
      .rd_en   (issue),
      .rd_addr (ib),
      .rd_data (b_data)
   );

   // Pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else if (adv) begin
         p1_valid_ff <= issue;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   // Tags and product register
   always_ff @(posedge clock) begin
      if (adv) begin
         p1_tag_ff <= issue_tag;
         p2_tag_ff <= p1_tag_ff;
         prod_ff   <= $signed(a_data) * $signed(b_data);
      end
   end

   // Accumulate, then floor-shift and saturate on the last term
   assign sum     = (p2_tag_ff.first ? '0 : acc_ff) + ACC_W'(prod_ff);
   assign shifted = sum >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (adv && p2_valid_ff && !p2_tag_ff.last) begin
         acc_ff <= sum;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= p2_valid_ff && p2_tag_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && p2_valid_ff && p2_tag_ff.last) begin
         rsp_index_ff <= p2_tag_ff.ridx;
         rsp_last_ff  <= p2_tag_ff.final_elem;
         if (shifted > Q_MAX) begin
            rsp_value_ff <= VAL_W'(Q_MAX);
            rsp_sat_ff   <= 1'b1;
         end else if (shifted < Q_MIN) begin
            rsp_value_ff <= VAL_W'(Q_MIN);
            rsp_sat_ff   <= 1'b1;
         end else begin
            rsp_value_ff <= shifted[VAL_W-1:0];
            rsp_sat_ff   <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.result_value = rsp_value_ff;
   assign rsp_chan.result_index = rsp_index_ff;
   assign rsp_chan.result_last  = rsp_last_ff;
   assign rsp_chan.saturated    = rsp_sat_ff;

endmodule

`default_nettype wire

// ===== hdl/fmm_checker.sv =====
// Port-level checks for the matrix multiplier, bound to the top level.
`default_nettype none

module fmm_checker import fmm_pkg::*; (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_ready,
   input wire logic [CMD_W-1:0]        req_cmd,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic signed [VAL_W-1:0] rsp_value,
   input wire logic [RIDX_W-1:0]       rsp_index,
   input wire logic                    rsp_last,
   input wire logic                    rsp_sat
);

   // No result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A compute transaction blocks new requests on the next cycle
   a_compute_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_cmd == CMD_COMPUTE) |=> !req_ready)
      else $error("request accepted during compute");

   // A saturated element sits at one of the range limits
   a_sat_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sat) |->
         (rsp_value == 16'sh7FFF || rsp_value == -16'sh8000))
      else $error("saturated flag without clipped value");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_value) && $stable(rsp_index)
          && $stable(rsp_last) && $stable(rsp_sat)))
      else $error("response dropped or changed while stalled");

endmodule

bind fixed_point_matrix_multiply_top fmm_checker u_fmm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_cmd   (req_chan.cmd),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_value (rsp_chan.result_value),
   .rsp_index (rsp_chan.result_index),
   .rsp_last  (rsp_chan.result_last),
   .rsp_sat   (rsp_chan.saturated)
);

`default_nettype wire
